// File: rtl/assert_macros.svh
// Assertion macros for the checker file of the keyword hash lookup block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is asserted.
`define KHL_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// Concurrent assertion that is checked during reset as well.
`define KHL_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/khl_pkg.sv
// Shared constants, types and a helper function of the keyword hash lookup block.
package khl_pkg;

	// Table geometry.
	localparam int SLOTS        = 512;
	localparam int NAME_CHARS   = 8;
	localparam int MASK_ENTRIES = 128;

	// Derived widths.
	localparam int SLOT_W  = $clog2(SLOTS);
	localparam int N_W     = $clog2(SLOTS + 1);
	localparam int SUM_W   = N_W + 1;
	localparam int POS_W   = $clog2(NAME_CHARS + 1);
	localparam int MASK_AW = $clog2(MASK_ENTRIES);
	localparam int HASH_W  = 16;
	localparam int HBIT_W  = $clog2(HASH_W);

	// Field widths of the channels.
	localparam int OPCODE_W     = 2;
	localparam int SLOT_FIELD_W = 9;
	localparam int NAME_W       = 64;
	localparam int ID_W         = 8;
	localparam int FLAGS_W      = 16;
	localparam int CHAR_W       = 8;
	localparam int MASK_W       = 8;
	localparam int SLOT_DW      = 1 + NAME_W + ID_W + FLAGS_W;

	// Configuration port.
	localparam int TSIZE_W    = 10;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 10;

	localparam logic [TSIZE_W-1:0] TABLE_SIZE_RESET  = 10'd331;
	localparam logic               CHECK_CHARS_RESET = 1'b1;

	// Character folding.
	localparam logic [CHAR_W-1:0] UPPER_A   = 8'h41;
	localparam logic [CHAR_W-1:0] UPPER_Z   = 8'h5A;
	localparam logic [CHAR_W-1:0] CASE_FOLD = 8'h20;

	typedef enum logic [OPCODE_W-1:0] {
		OP_WRITE_SLOT = 2'd0,
		OP_WRITE_MASK = 2'd1,
		OP_CHAR       = 2'd2,
		OP_NONE       = 2'd3
	} opcode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TABLE_SIZE  = 1'b0,
		CFG_CHECK_CHARS = 1'b1
	} cfg_idx_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clr;
		logic accept;
		logic char_upd;
		logic mod_step;
		logic probe_rd;
		logic probe_adv;
		logic res_set;
		logic res_hit;
		logic out_load;
	} khl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clr_last;
		logic item_is_char;
		logic char_last;
		logic mod_last;
		logic skip;
		logic slot_empty;
		logic slot_match;
		logic probes_last;
		logic out_free;
	} khl_status_t;

	// Upper-case letters fold to lower case; every other code passes.
	function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] c);
		logic [CHAR_W-1:0] r;
		r = c;
		if (c >= UPPER_A && c <= UPPER_Z) begin
			r = c + CASE_FOLD;
		end
		return r;
	endfunction

endpackage

// File: rtl/khl_if.sv
// Valid/ready channel interfaces for input items and lookup results.
interface khl_item_if;
	logic                              valid;
	logic                              ready;
	logic [khl_pkg::OPCODE_W-1:0]      opcode;
	logic [khl_pkg::SLOT_FIELD_W-1:0]  slot;
	logic [khl_pkg::NAME_W-1:0]        entry_name;
	logic [khl_pkg::ID_W-1:0]          entry_id;
	logic [khl_pkg::FLAGS_W-1:0]       entry_flags;
	logic                              entry_valid;
	logic [khl_pkg::CHAR_W-1:0]        char_code;
	logic [khl_pkg::MASK_W-1:0]        mask_bits;
	logic                              last;

	modport source (
		output valid, opcode, slot, entry_name, entry_id, entry_flags, entry_valid,
		output char_code, mask_bits, last,
		input  ready
	);
	modport sink (
		input  valid, opcode, slot, entry_name, entry_id, entry_flags, entry_valid,
		input  char_code, mask_bits, last,
		output ready
	);
endinterface

interface khl_result_if;
	logic                              valid;
	logic                              ready;
	logic                              found;
	logic [khl_pkg::ID_W-1:0]          token_id;
	logic [khl_pkg::FLAGS_W-1:0]       token_flags;
	logic [khl_pkg::SLOT_FIELD_W-1:0]  match_slot;

	modport source (
		output valid, found, token_id, token_flags, match_slot,
		input  ready
	);
	modport sink (
		input  valid, found, token_id, token_flags, match_slot,
		output ready
	);
endinterface

// File: rtl/khl_ram.sv
// Generic single-port RAM with registered read data.
module khl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// One access per cycle; read data holds until the next read.
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata_q <= mem[addr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/khl_ctrl.sv
// Controller state machine of the keyword hash lookup block.
module khl_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  khl_pkg::khl_status_t status,
	output khl_pkg::khl_cmd_t    cmd
);

	typedef enum logic [6:0] {
		ST_CLEAR     = 7'b0000001,
		ST_IDLE      = 7'b0000010,
		ST_CHAR      = 7'b0000100,
		ST_MOD       = 7'b0001000,
		ST_PROBE_RD  = 7'b0010000,
		ST_PROBE_CHK = 7'b0100000,
		ST_RESULT    = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_d;

	// State register; reset starts the table clearing sweep.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Only the idle state takes input beats.
	assign item_ready = (state_q == ST_IDLE);

	// Next state and datapath commands.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr = 1'b1;
				if (status.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				cmd.accept = item_valid;
				if (item_valid && status.item_is_char) begin
					state_d = ST_CHAR;
				end
			end
			ST_CHAR: begin
				cmd.char_upd = 1'b1;
				state_d = status.char_last ? ST_MOD : ST_IDLE;
			end
			ST_MOD: begin
				cmd.mod_step = 1'b1;
				if (status.mod_last) begin
					if (status.skip) begin
						cmd.res_set = 1'b1;
						state_d     = ST_RESULT;
					end else begin
						state_d = ST_PROBE_RD;
					end
				end
			end
			ST_PROBE_RD: begin
				cmd.probe_rd = 1'b1;
				state_d      = ST_PROBE_CHK;
			end
			ST_PROBE_CHK: begin
				if (status.slot_empty || status.slot_match || status.probes_last) begin
					cmd.res_set = 1'b1;
					cmd.res_hit = status.slot_match;
					state_d     = ST_RESULT;
				end else begin
					cmd.probe_adv = 1'b1;
					state_d       = ST_PROBE_RD;
				end
			end
			ST_RESULT: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

endmodule

// File: rtl/khl_dp.sv
// Datapath: configuration, slot and mask memories, name hashing, remainder unit and prober.
module khl_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  khl_pkg::khl_cmd_t                    cmd,
	output khl_pkg::khl_status_t                 status,
	input  logic                                 cfg_we,
	input  logic [khl_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [khl_pkg::CFG_DATA_W-1:0]       cfg_wdata,
	input  logic [khl_pkg::OPCODE_W-1:0]         opcode,
	input  logic [khl_pkg::SLOT_FIELD_W-1:0]     slot,
	input  logic [khl_pkg::NAME_W-1:0]           entry_name,
	input  logic [khl_pkg::ID_W-1:0]             entry_id,
	input  logic [khl_pkg::FLAGS_W-1:0]          entry_flags,
	input  logic                                 entry_valid,
	input  logic [khl_pkg::CHAR_W-1:0]           char_code,
	input  logic [khl_pkg::MASK_W-1:0]           mask_bits,
	input  logic                                 last,
	input  logic                                 result_ready,
	output logic                                 result_valid,
	output logic                                 found,
	output logic [khl_pkg::ID_W-1:0]             token_id,
	output logic [khl_pkg::FLAGS_W-1:0]          token_flags,
	output logic [khl_pkg::SLOT_FIELD_W-1:0]     match_slot
);

	// Configuration registers.
	logic [khl_pkg::TSIZE_W-1:0] table_size_q;
	logic                        check_chars_q;
	logic [khl_pkg::N_W-1:0]     n;

	// Clearing sweep and captured character.
	logic [khl_pkg::SLOT_W-1:0]  clr_cnt_q;
	logic [khl_pkg::CHAR_W-1:0]  char_fold;
	logic [khl_pkg::CHAR_W-1:0]  char_q;
	logic                        last_q;

	// Per-name state.
	logic [khl_pkg::HASH_W-1:0]  hash_q;
	logic [khl_pkg::HASH_W-1:0]  hash_next;
	logic [khl_pkg::POS_W-1:0]   pos_q;
	logic [khl_pkg::NAME_W-1:0]  name_q;
	logic [khl_pkg::NAME_W-1:0]  name_next;
	logic                        rejected_q;
	logic                        too_long_q;
	logic                        pos_in_name;
	logic                        mask_hit;

	// Remainder unit.
	logic [khl_pkg::N_W-1:0]     rem_q;
	logic [khl_pkg::N_W-1:0]     rem_next;
	logic [khl_pkg::N_W:0]       rem_shift;
	logic [khl_pkg::HBIT_W-1:0]  bitcnt_q;

	// Prober.
	logic [khl_pkg::SLOT_W-1:0]  idx_q;
	logic [khl_pkg::SLOT_W-1:0]  idx_next;
	logic [khl_pkg::SLOT_W-1:0]  step_q;
	logic [khl_pkg::SLOT_W-1:0]  step_next;
	logic [khl_pkg::SLOT_W-1:0]  step_init;
	logic [khl_pkg::N_W-1:0]     probes_q;
	logic [khl_pkg::SUM_W-1:0]   idx_sum;
	logic [khl_pkg::SUM_W-1:0]   step_sum;
	logic                        found_q;

	// Memory ports.
	logic                         slot_en;
	logic                         slot_we;
	logic [khl_pkg::SLOT_W-1:0]   slot_addr;
	logic [khl_pkg::SLOT_DW-1:0]  slot_wdata;
	logic [khl_pkg::SLOT_DW-1:0]  slot_rdata;
	logic                         rd_valid;
	logic [khl_pkg::NAME_W-1:0]   rd_name;
	logic [khl_pkg::ID_W-1:0]     rd_id;
	logic [khl_pkg::FLAGS_W-1:0]  rd_flags;
	logic                         mask_en;
	logic                         mask_we;
	logic [khl_pkg::MASK_AW-1:0]  mask_addr;
	logic [khl_pkg::MASK_W-1:0]   mask_wdata;
	logic [khl_pkg::MASK_W-1:0]   mask_rdata;

	// Result register.
	logic                            res_valid_q;
	logic                            res_found_q;
	logic [khl_pkg::ID_W-1:0]        res_id_q;
	logic [khl_pkg::FLAGS_W-1:0]     res_flags_q;
	logic [khl_pkg::SLOT_FIELD_W-1:0] res_slot_q;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_size_q  <= khl_pkg::TABLE_SIZE_RESET;
			check_chars_q <= khl_pkg::CHECK_CHARS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				khl_pkg::CFG_TABLE_SIZE:  table_size_q  <= cfg_wdata[khl_pkg::TSIZE_W-1:0];
				khl_pkg::CFG_CHECK_CHARS: check_chars_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// Effective modulus: zero counts as one, large sizes saturate.
	always_comb begin
		if (table_size_q == '0) begin
			n = khl_pkg::N_W'(1);
		end else if (int'(table_size_q) > khl_pkg::SLOTS) begin
			n = khl_pkg::N_W'(khl_pkg::SLOTS);
		end else begin
			n = khl_pkg::N_W'(table_size_q);
		end
	end

	// Clearing sweep counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clr) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	// Capture the folded character and its last mark when a name beat is taken.
	assign char_fold = khl_pkg::fold_case(char_code);

	always_ff @(posedge clk) begin
		if (cmd.accept && opcode == khl_pkg::OP_CHAR) begin
			char_q <= char_fold;
			last_q <= last;
		end
	end

	// Slot memory port selection.
	always_comb begin
		slot_en    = 1'b0;
		slot_we    = 1'b0;
		slot_addr  = idx_q;
		slot_wdata = {entry_valid, entry_name, entry_id, entry_flags};
		if (cmd.clr) begin
			slot_en    = 1'b1;
			slot_we    = 1'b1;
			slot_addr  = clr_cnt_q;
			slot_wdata = '0;
		end else if (cmd.accept && opcode == khl_pkg::OP_WRITE_SLOT &&
				int'(slot) < khl_pkg::SLOTS) begin
			slot_en   = 1'b1;
			slot_we   = 1'b1;
			slot_addr = khl_pkg::SLOT_W'(slot);
		end else if (cmd.probe_rd) begin
			slot_en = 1'b1;
		end
	end

	// Mask memory port selection.
	always_comb begin
		mask_en    = 1'b0;
		mask_we    = 1'b0;
		mask_addr  = khl_pkg::MASK_AW'(char_fold);
		mask_wdata = mask_bits;
		if (cmd.clr) begin
			if (int'(clr_cnt_q) < khl_pkg::MASK_ENTRIES) begin
				mask_en    = 1'b1;
				mask_we    = 1'b1;
				mask_addr  = khl_pkg::MASK_AW'(clr_cnt_q);
				mask_wdata = '0;
			end
		end else if (cmd.accept && opcode == khl_pkg::OP_WRITE_MASK) begin
			if (int'(char_code) < khl_pkg::MASK_ENTRIES) begin
				mask_en   = 1'b1;
				mask_we   = 1'b1;
				mask_addr = khl_pkg::MASK_AW'(char_code);
			end
		end else if (cmd.accept && opcode == khl_pkg::OP_CHAR) begin
			mask_en = 1'b1;
		end
	end

	khl_ram #(
		.WIDTH (khl_pkg::SLOT_DW),
		.DEPTH (khl_pkg::SLOTS)
	) u_slot_ram (
		.clk   (clk),
		.en    (slot_en),
		.we    (slot_we),
		.addr  (slot_addr),
		.wdata (slot_wdata),
		.rdata (slot_rdata)
	);

	khl_ram #(
		.WIDTH (khl_pkg::MASK_W),
		.DEPTH (khl_pkg::MASK_ENTRIES)
	) u_mask_ram (
		.clk   (clk),
		.en    (mask_en),
		.we    (mask_we),
		.addr  (mask_addr),
		.wdata (mask_wdata),
		.rdata (mask_rdata)
	);

	assign {rd_valid, rd_name, rd_id, rd_flags} = slot_rdata;

	// Character update: position check, byte insert and hash fold.
	assign pos_in_name = int'(pos_q) < khl_pkg::NAME_CHARS;
	assign mask_hit    = check_chars_q && mask_rdata[3'(pos_q)];
	assign hash_next   = (hash_q >> 2) + {char_q[6:0], 9'b0};

	always_comb begin
		name_next = name_q;
		for (int k = 0; k < khl_pkg::NAME_CHARS; k++) begin
			if (pos_q == khl_pkg::POS_W'(k)) begin
				name_next[8*k +: 8] = char_q;
			end
		end
	end

	// Per-name registers clear once the result is loaded.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q     <= '0;
			pos_q      <= '0;
			name_q     <= '0;
			rejected_q <= 1'b0;
			too_long_q <= 1'b0;
		end else if (cmd.out_load) begin
			hash_q     <= '0;
			pos_q      <= '0;
			name_q     <= '0;
			rejected_q <= 1'b0;
			too_long_q <= 1'b0;
		end else if (cmd.char_upd) begin
			hash_q <= hash_next;
			if (pos_in_name) begin
				name_q <= name_next;
				pos_q  <= pos_q + 1'b1;
				if (mask_hit) begin
					rejected_q <= 1'b1;
				end
			end else begin
				too_long_q <= 1'b1;
			end
		end
	end

	// Remainder of the hash by the modulus, one hash bit per cycle from the top.
	// For a 4-bit counter the inverted count walks bit 15 down to bit 0.
	assign rem_shift = {rem_q, hash_q[~bitcnt_q]};
	assign rem_next  = (rem_shift >= {1'b0, n}) ? khl_pkg::N_W'(rem_shift - {1'b0, n})
	                                            : khl_pkg::N_W'(rem_shift);

	always_ff @(posedge clk) begin
		if (cmd.char_upd) begin
			rem_q    <= '0;
			bitcnt_q <= '0;
		end else if (cmd.mod_step) begin
			rem_q    <= rem_next;
			bitcnt_q <= bitcnt_q + 1'b1;
		end
	end

	// Quadratic probe step: the index sum stays below twice the modulus and the step sum below the modulus plus two.
	assign step_init = (n == khl_pkg::N_W'(1)) ? '0 : khl_pkg::SLOT_W'(1);

	always_comb begin
		idx_sum  = khl_pkg::SUM_W'(idx_q) + khl_pkg::SUM_W'(step_q);
		step_sum = khl_pkg::SUM_W'(step_q) + khl_pkg::SUM_W'(2);
		if (idx_sum >= khl_pkg::SUM_W'(n)) begin
			idx_sum = idx_sum - khl_pkg::SUM_W'(n);
		end
		if (step_sum >= khl_pkg::SUM_W'(n)) begin
			step_sum = step_sum - khl_pkg::SUM_W'(n);
		end
		idx_next  = khl_pkg::SLOT_W'(idx_sum);
		step_next = (n == khl_pkg::N_W'(1)) ? '0 : khl_pkg::SLOT_W'(step_sum);
	end

	always_ff @(posedge clk) begin
		if (cmd.mod_step && status.mod_last) begin
			idx_q    <= khl_pkg::SLOT_W'(rem_next);
			step_q   <= step_init;
			probes_q <= '0;
		end else if (cmd.probe_adv) begin
			idx_q    <= idx_next;
			step_q   <= step_next;
			probes_q <= probes_q + 1'b1;
		end
	end

	// Lookup outcome held until the result register is free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (cmd.res_set) begin
			found_q <= cmd.res_hit;
		end
	end

	// Result register; misses report zeros.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			res_valid_q <= 1'b1;
		end else if (result_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			res_found_q <= found_q;
			res_id_q    <= found_q ? rd_id : '0;
			res_flags_q <= found_q ? rd_flags : '0;
			res_slot_q  <= found_q ? khl_pkg::SLOT_FIELD_W'(idx_q) : '0;
		end
	end

	assign result_valid = res_valid_q;
	assign found        = res_found_q;
	assign token_id     = res_id_q;
	assign token_flags  = res_flags_q;
	assign match_slot   = res_slot_q;

	// Status toward the controller.
	always_comb begin
		status              = '0;
		status.clr_last     = (clr_cnt_q == khl_pkg::SLOT_W'(khl_pkg::SLOTS - 1));
		status.item_is_char = (opcode == khl_pkg::OP_CHAR);
		status.char_last    = last_q;
		status.mod_last     = (bitcnt_q == '1);
		status.skip         = rejected_q || too_long_q;
		status.slot_empty   = !rd_valid;
		status.slot_match   = rd_valid && (rd_name == name_q);
		status.probes_last  = (probes_q == n - 1'b1);
		status.out_free     = !res_valid_q || result_ready;
	end

endmodule

// File: rtl/keyword_hash_lookup.sv
// Top level of the keyword hash lookup block: controller plus datapath.
//
// Input beats arrive on item: opcode 0 loads a hash slot (name, id, flags,
// valid), opcode 1 loads a per-position invalid-character mask entry,
// opcode 2 streams one name character, opcode 3 is taken and ignored.
// Result beats leave on result: one per name, on the character marked last.
// Registers table_size and check_chars are written through cfg_we/cfg_index/
// cfg_wdata; the user must write them only while no name is in flight, as the
// block itself does not enforce this. A slot or mask write is done when it is
// taken; a name character is taken and then folded into the name and hash,
// with the mask memory read. After the last character the hash remainder unit
// works through the hash bits from the top, each probe reads a slot and
// compares its name, and the result register is then loaded.
// After reset a sweep over every slot clears the slot valid bits and the
// mask memory; item.ready stays low during it.
// A stalled result stays in the output register while new items are taken;
// only a following lookup waits for that register to drain.
module keyword_hash_lookup (
	input  logic                           clk,
	input  logic                           arst_n,
	khl_item_if.sink                       item,
	khl_result_if.source                   result,
	input  logic                           cfg_we,
	input  logic [khl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [khl_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	khl_pkg::khl_cmd_t    cmd;
	khl_pkg::khl_status_t status;
	logic                 item_ready;

	assign item.ready = item_ready;

	// Sequencer.
	khl_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_ready (item_ready),
		.status     (status),
		.cmd        (cmd)
	);

	// Storage, hashing and probing.
	khl_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.opcode       (item.opcode),
		.slot         (item.slot),
		.entry_name   (item.entry_name),
		.entry_id     (item.entry_id),
		.entry_flags  (item.entry_flags),
		.entry_valid  (item.entry_valid),
		.char_code    (item.char_code),
		.mask_bits    (item.mask_bits),
		.last         (item.last),
		.result_ready (result.ready),
		.result_valid (result.valid),
		.found        (result.found),
		.token_id     (result.token_id),
		.token_flags  (result.token_flags),
		.match_slot   (result.match_slot)
	);

endmodule

// File: rtl/khl_checker.sv
// Port-level checker for the keyword hash lookup block and its bind.
`include "assert_macros.svh"

module khl_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              item_valid,
	input logic                              item_ready,
	input logic [khl_pkg::OPCODE_W-1:0]      item_opcode,
	input logic                              result_valid,
	input logic                              result_ready,
	input logic                              found,
	input logic [khl_pkg::ID_W-1:0]          token_id,
	input logic [khl_pkg::FLAGS_W-1:0]       token_flags,
	input logic [khl_pkg::SLOT_FIELD_W-1:0]  match_slot
);

	// A stalled result beat is not withdrawn.
	`KHL_ASSERT(a_result_hold, clk, arst_n, result_valid && !result_ready |=> result_valid, "result beat withdrawn while stalled")

	// A miss reports zero id, flags and slot.
	`KHL_ASSERT(a_miss_zero, clk, arst_n, result_valid && !found |-> token_id == '0 && token_flags == '0 && match_slot == '0, "miss with nonzero payload")

	// Right after a name character is taken the block is busy and input is not ready.
	`KHL_ASSERT(a_char_busy, clk, arst_n, item_valid && item_ready && item_opcode == khl_pkg::OP_CHAR |=> !item_ready, "input ready right after a name character")

	// The clearing sweep holds off input right after reset.
	`KHL_ASSERT(a_clear_after_reset, clk, arst_n, $rose(arst_n) |-> !item_ready, "input ready before the clearing sweep")

	// Nothing moves while reset stays asserted: no result beat is valid and input is not ready.
	`KHL_ASSERT_ALWAYS(a_reset_quiet, clk, !arst_n && $past(!arst_n) |-> !result_valid && !item_ready, "activity during reset")

endmodule

bind keyword_hash_lookup khl_checker u_khl_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item.valid),
	.item_ready   (item.ready),
	.item_opcode  (item.opcode),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.found        (result.found),
	.token_id     (result.token_id),
	.token_flags  (result.token_flags),
	.match_slot   (result.match_slot)
);
